FILE: rtl/core/eclip_pkg.sv
package eclip_pkg;

	// Default store depth and fixed field widths
	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_W          = 16;
	localparam int CORNER_W         = 6;
	localparam int TRI_W            = 3 * CORNER_W;
	localparam int THR_W            = 16;
	localparam int DIFF_W           = COORD_W + 1;
	localparam int PROD_W           = 2 * DIFF_W;
	localparam int CROSS_W          = PROD_W + 1;

	localparam logic [THR_W-1:0] THR_RESET = 16'd1;

	// Result status codes
	localparam logic [1:0] ST_TRI = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;
	localparam logic [1:0] ST_OVF = 2'd3;

	// Coordinate register load codes
	localparam logic [2:0] LAT_NONE = 3'd0;
	localparam logic [2:0] LAT_A    = 3'd1;
	localparam logic [2:0] LAT_B    = 3'd2;
	localparam logic [2:0] LAT_C    = 3'd3;
	localparam logic [2:0] LAT_P    = 3'd4;
	localparam logic [2:0] LAT_MOVE = 3'd5;

	// Cross product operand selects
	localparam logic [2:0] X_AREA = 3'd0;
	localparam logic [2:0] X_K1   = 3'd1;
	localparam logic [2:0] X_K2   = 3'd2;
	localparam logic [2:0] X_K3   = 3'd3;
	localparam logic [2:0] X_SHOE = 3'd4;

	typedef struct packed {
		logic       v_we;
		logic [2:0] lat;
		logic [2:0] xsel;
		logic       o_we;
		logic       t_we;
		logic       out_ld;
		logic       out_tri;
		logic [1:0] out_status;
		logic       out_last;
		logic       relaxed;
		logic       sum_clr;
		logic       sum_add;
	} eclip_cmd_t;

	typedef struct packed {
		logic ge_thr;
		logic pos;
		logic sum_pos;
	} eclip_sts_t;

endpackage

FILE: rtl/core/eclip_if.sv
interface eclip_vtx_if;
	logic                        valid;
	logic                        ready;
	logic signed [15:0]          vertex_x;
	logic signed [15:0]          vertex_y;
	logic                        last_vertex;

	modport source(output valid, output vertex_x, output vertex_y, output last_vertex,
		input ready);
	modport sink(input valid, input vertex_x, input vertex_y, input last_vertex,
		output ready);
endinterface

interface eclip_tri_if;
	logic       valid;
	logic       ready;
	logic [5:0] corner_a;
	logic [5:0] corner_b;
	logic [5:0] corner_c;
	logic [1:0] status;
	logic       last_result;

	modport source(output valid, output corner_a, output corner_b, output corner_c,
		output status, output last_result, input ready);
	modport sink(input valid, input corner_a, input corner_b, input corner_c,
		input status, input last_result, output ready);
endinterface

interface eclip_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/eclip_dp.sv
module eclip_dp #(
	parameter int MAX_VERTICES = eclip_pkg::MAX_VERTICES_DEF,
	localparam int IW = $clog2(MAX_VERTICES)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  eclip_pkg::eclip_cmd_t                cmd,
	output eclip_pkg::eclip_sts_t                sts,
	input  logic [IW-1:0]                        vaddr,
	input  logic signed [eclip_pkg::COORD_W-1:0] vertex_x,
	input  logic signed [eclip_pkg::COORD_W-1:0] vertex_y,
	input  logic [IW-1:0]                        oaddr,
	input  logic [IW-1:0]                        o_waddr,
	input  logic [IW-1:0]                        o_wdata,
	output logic [IW-1:0]                        ord_rd,
	input  logic [IW-1:0]                        taddr,
	input  logic [IW-1:0]                        t_waddr,
	input  logic [eclip_pkg::TRI_W-1:0]          t_wdata,
	input  logic                                 cfg_we,
	input  logic [eclip_pkg::THR_W-1:0]          cfg_data,
	output logic [eclip_pkg::CORNER_W-1:0]       corner_a,
	output logic [eclip_pkg::CORNER_W-1:0]       corner_b,
	output logic [eclip_pkg::CORNER_W-1:0]       corner_c,
	output logic [1:0]                           status,
	output logic                                 last_result
);
	localparam int CW = eclip_pkg::CROSS_W;
	localparam int PW = eclip_pkg::PROD_W;
	localparam int DW = eclip_pkg::DIFF_W;
	localparam int XW = eclip_pkg::COORD_W;
	localparam int SW = CW + IW + 1;

	logic [2*XW-1:0]             vmem [MAX_VERTICES];
	logic [IW-1:0]               omem [MAX_VERTICES];
	logic [eclip_pkg::TRI_W-1:0] tmem [MAX_VERTICES];

	logic [2*XW-1:0]             vrd_q;
	logic [eclip_pkg::TRI_W-1:0] trd_q;
	logic [IW-1:0]               ord_q;
	logic [eclip_pkg::THR_W-1:0] thr_q;

	logic signed [XW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q, px_q, py_q;
	logic signed [XW-1:0] ox, oy, sx, sy, qx, qy;
	logic signed [DW-1:0] dpx, dpy, dqx, dqy;
	logic signed [PW-1:0] m1_d, m2_d, m1_s1, m2_s1;
	logic signed [CW-1:0] cross_q, thr_pos, thr_cmp;
	logic signed [SW-1:0] sum_q;

	// Memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (cmd.v_we) begin
			vmem[vaddr] <= {vertex_x, vertex_y};
		end
		vrd_q <= vmem[vaddr];
		if (cmd.o_we) begin
			omem[o_waddr] <= o_wdata;
		end
		ord_q <= omem[oaddr];
		if (cmd.t_we) begin
			tmem[t_waddr] <= t_wdata;
		end
		trd_q <= tmem[taddr];
	end

	assign ord_rd = ord_q;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= eclip_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// Load corner and probe coordinates from the read port
	always_ff @(posedge clk) begin
		case (cmd.lat)
			eclip_pkg::LAT_A: begin
				ax_q <= vrd_q[2*XW-1:XW];
				ay_q <= vrd_q[XW-1:0];
			end
			eclip_pkg::LAT_B: begin
				bx_q <= vrd_q[2*XW-1:XW];
				by_q <= vrd_q[XW-1:0];
			end
			eclip_pkg::LAT_C: begin
				cx_q <= vrd_q[2*XW-1:XW];
				cy_q <= vrd_q[XW-1:0];
			end
			eclip_pkg::LAT_P: begin
				px_q <= vrd_q[2*XW-1:XW];
				py_q <= vrd_q[XW-1:0];
			end
			eclip_pkg::LAT_MOVE: begin
				ax_q <= px_q;
				ay_q <= py_q;
			end
			default: begin
			end
		endcase
	end

	// Pick origin and the two arms of the cross product
	always_comb begin
		ox = ax_q; oy = ay_q; sx = bx_q; sy = by_q; qx = cx_q; qy = cy_q;
		case (cmd.xsel)
			eclip_pkg::X_AREA: begin
				ox = ax_q; oy = ay_q; sx = bx_q; sy = by_q; qx = cx_q; qy = cy_q;
			end
			eclip_pkg::X_K1: begin
				ox = bx_q; oy = by_q; sx = cx_q; sy = cy_q; qx = px_q; qy = py_q;
			end
			eclip_pkg::X_K2: begin
				ox = cx_q; oy = cy_q; sx = ax_q; sy = ay_q; qx = px_q; qy = py_q;
			end
			eclip_pkg::X_K3: begin
				ox = ax_q; oy = ay_q; sx = bx_q; sy = by_q; qx = px_q; qy = py_q;
			end
			eclip_pkg::X_SHOE: begin
				ox = '0; oy = '0; sx = ax_q; sy = ay_q; qx = px_q; qy = py_q;
			end
			default: begin
			end
		endcase
	end

	assign dpx  = {sx[XW-1], sx} - {ox[XW-1], ox};
	assign dpy  = {sy[XW-1], sy} - {oy[XW-1], oy};
	assign dqx  = {qx[XW-1], qx} - {ox[XW-1], ox};
	assign dqy  = {qy[XW-1], qy} - {oy[XW-1], oy};
	assign m1_d = dpx * dqy;
	assign m2_d = dpy * dqx;

	// Products in one stage, difference in the next
	always_ff @(posedge clk) begin
		m1_s1   <= m1_d;
		m2_s1   <= m2_d;
		cross_q <= {m1_s1[PW-1], m1_s1} - {m2_s1[PW-1], m2_s1};
	end

	// Shoelace accumulator
	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.sum_add) begin
			sum_q <= sum_q + {{(SW-CW){cross_q[CW-1]}}, cross_q};
		end
	end

	// Compare against the threshold, negated in relaxed mode
	assign thr_pos = $signed({{(CW-eclip_pkg::THR_W){1'b0}}, thr_q});
	assign thr_cmp = cmd.relaxed ? -thr_pos : thr_pos;

	assign sts.ge_thr  = cross_q >= thr_cmp;
	assign sts.pos     = cmd.relaxed ? (!cross_q[CW-1] && (cross_q != '0)) : !cross_q[CW-1];
	assign sts.sum_pos = !sum_q[SW-1] && (sum_q != '0);

	// Result payload register
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			if (cmd.out_tri) begin
				corner_a <= trd_q[3*eclip_pkg::CORNER_W-1:2*eclip_pkg::CORNER_W];
				corner_b <= trd_q[2*eclip_pkg::CORNER_W-1:eclip_pkg::CORNER_W];
				corner_c <= trd_q[eclip_pkg::CORNER_W-1:0];
			end else begin
				corner_a <= '0;
				corner_b <= '0;
				corner_c <= '0;
			end
			status      <= cmd.out_status;
			last_result <= cmd.out_last;
		end
	end

endmodule

FILE: rtl/core/eclip_ctrl.sv
module eclip_ctrl #(
	parameter int MAX_VERTICES = eclip_pkg::MAX_VERTICES_DEF,
	localparam int IW = $clog2(MAX_VERTICES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_last,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output eclip_pkg::eclip_cmd_t         cmd,
	input  eclip_pkg::eclip_sts_t         sts,
	output logic [IW-1:0]                 vaddr,
	output logic [IW-1:0]                 oaddr,
	output logic [IW-1:0]                 o_waddr,
	output logic [IW-1:0]                 o_wdata,
	input  logic [IW-1:0]                 ord_rd,
	output logic [IW-1:0]                 taddr,
	output logic [IW-1:0]                 t_waddr,
	output logic [eclip_pkg::TRI_W-1:0]   t_wdata
);
	localparam logic [IW:0] MAXV = (IW+1)'(MAX_VERTICES);
	localparam logic [IW:0] ONE  = (IW+1)'(1);
	localparam logic [IW:0] TWO  = (IW+1)'(2);
	localparam logic [IW:0] THREE = (IW+1)'(3);

	localparam logic [5:0] S_LOAD  = 6'd0;
	localparam logic [5:0] S_DEC   = 6'd1;
	localparam logic [5:0] S_SL0   = 6'd2;
	localparam logic [5:0] S_SL1   = 6'd3;
	localparam logic [5:0] S_SL2   = 6'd4;
	localparam logic [5:0] S_SL3   = 6'd5;
	localparam logic [5:0] S_SL4   = 6'd6;
	localparam logic [5:0] S_SL5   = 6'd7;
	localparam logic [5:0] S_SL6   = 6'd8;
	localparam logic [5:0] S_INIT  = 6'd9;
	localparam logic [5:0] S_LOOP  = 6'd10;
	localparam logic [5:0] S_E0    = 6'd11;
	localparam logic [5:0] S_E1    = 6'd12;
	localparam logic [5:0] S_E2    = 6'd13;
	localparam logic [5:0] S_E3    = 6'd14;
	localparam logic [5:0] S_E4    = 6'd15;
	localparam logic [5:0] S_E5    = 6'd16;
	localparam logic [5:0] S_E6    = 6'd17;
	localparam logic [5:0] S_E7    = 6'd18;
	localparam logic [5:0] S_E8    = 6'd19;
	localparam logic [5:0] S_PL    = 6'd20;
	localparam logic [5:0] S_P1    = 6'd21;
	localparam logic [5:0] S_P2    = 6'd22;
	localparam logic [5:0] S_P3    = 6'd23;
	localparam logic [5:0] S_P4    = 6'd24;
	localparam logic [5:0] S_P5    = 6'd25;
	localparam logic [5:0] S_P6    = 6'd26;
	localparam logic [5:0] S_P7    = 6'd27;
	localparam logic [5:0] S_EAR   = 6'd28;
	localparam logic [5:0] S_SHF   = 6'd29;
	localparam logic [5:0] S_SHW   = 6'd30;
	localparam logic [5:0] S_FAIL  = 6'd31;
	localparam logic [5:0] S_EM0   = 6'd32;
	localparam logic [5:0] S_EM1   = 6'd33;
	localparam logic [5:0] S_OWAIT = 6'd34;

	logic [5:0]    state_q;
	logic [IW:0]   cnt_q, nv_q, i_q, u_q, v_q, w_q, tcnt_q;
	logic [IW+1:0] count_q;
	logic          ovf_q, relaxed_q, f1_q, f2_q, olast_q;
	logic [1:0]    fst_q;
	logic [IW-1:0] ia_q, ib_q, ic_q;
	logic [IW:0]   cnt_m1, uu, vv, ww, i_p1;

	assign cnt_m1 = cnt_q - ONE;
	assign i_p1   = i_q + ONE;

	// Next ear candidate, wrapped around the remaining ring
	always_comb begin
		uu = (v_q >= nv_q) ? '0 : v_q;
		vv = ((uu + ONE) >= nv_q) ? '0 : (uu + ONE);
		ww = ((vv + ONE) >= nv_q) ? '0 : (vv + ONE);
	end

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OWAIT);

	// Commands to the datapath
	always_comb begin
		cmd            = '0;
		cmd.relaxed    = relaxed_q;
		cmd.out_status = fst_q;
		vaddr          = '0;
		oaddr          = '0;
		o_waddr        = i_q[IW-1:0];
		o_wdata        = ord_rd;
		taddr          = i_q[IW-1:0];
		t_waddr        = tcnt_q[IW-1:0];
		t_wdata        = {eclip_pkg::CORNER_W'(ia_q), eclip_pkg::CORNER_W'(ib_q),
			eclip_pkg::CORNER_W'(ic_q)};
		case (state_q)
			S_LOAD: begin
				vaddr    = cnt_q[IW-1:0];
				cmd.v_we = in_valid && (cnt_q < MAXV);
			end
			S_DEC: cmd.sum_clr = 1'b1;
			S_SL0: vaddr = cnt_m1[IW-1:0];
			S_SL1: cmd.lat = eclip_pkg::LAT_A;
			S_SL2: vaddr = i_q[IW-1:0];
			S_SL3: cmd.lat = eclip_pkg::LAT_P;
			S_SL4: cmd.xsel = eclip_pkg::X_SHOE;
			S_SL6: begin
				cmd.sum_add = 1'b1;
				cmd.lat     = eclip_pkg::LAT_MOVE;
			end
			S_INIT: begin
				cmd.o_we = 1'b1;
				o_wdata  = sts.sum_pos ? i_q[IW-1:0] : (cnt_m1[IW-1:0] - i_q[IW-1:0]);
			end
			S_E0: oaddr = u_q[IW-1:0];
			S_E1: oaddr = v_q[IW-1:0];
			S_E2: begin
				oaddr = w_q[IW-1:0];
				vaddr = ia_q;
			end
			S_E3: begin
				vaddr   = ib_q;
				cmd.lat = eclip_pkg::LAT_A;
			end
			S_E4: begin
				vaddr   = ic_q;
				cmd.lat = eclip_pkg::LAT_B;
			end
			S_E5: cmd.lat = eclip_pkg::LAT_C;
			S_E6: cmd.xsel = eclip_pkg::X_AREA;
			S_PL: oaddr = i_q[IW-1:0];
			S_P1: vaddr = ord_rd;
			S_P2: cmd.lat = eclip_pkg::LAT_P;
			S_P3: cmd.xsel = eclip_pkg::X_K1;
			S_P4: cmd.xsel = eclip_pkg::X_K2;
			S_P5: cmd.xsel = eclip_pkg::X_K3;
			S_EAR: cmd.t_we = 1'b1;
			S_SHF: oaddr = i_p1[IW-1:0];
			S_SHW: cmd.o_we = 1'b1;
			S_FAIL: begin
				cmd.out_ld   = 1'b1;
				cmd.out_last = 1'b1;
			end
			S_EM1: begin
				cmd.out_ld     = 1'b1;
				cmd.out_tri    = 1'b1;
				cmd.out_status = eclip_pkg::ST_TRI;
				cmd.out_last   = (i_q == (tcnt_q - ONE));
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			tcnt_q    <= '0;
			nv_q      <= '0;
			i_q       <= '0;
			u_q       <= '0;
			v_q       <= '0;
			w_q       <= '0;
			count_q   <= '0;
			relaxed_q <= 1'b0;
			f1_q      <= 1'b0;
			f2_q      <= 1'b0;
			olast_q   <= 1'b0;
			fst_q     <= eclip_pkg::ST_TRI;
			ia_q      <= '0;
			ib_q      <= '0;
			ic_q      <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (cnt_q < MAXV) begin
							cnt_q <= cnt_q + ONE;
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							state_q <= S_DEC;
						end
					end
				end
				S_DEC: begin
					if (ovf_q) begin
						fst_q   <= eclip_pkg::ST_OVF;
						state_q <= S_FAIL;
					end else if (cnt_q < THREE) begin
						fst_q   <= eclip_pkg::ST_FEW;
						state_q <= S_FAIL;
					end else begin
						state_q <= S_SL0;
					end
				end
				S_SL0: state_q <= S_SL1;
				S_SL1: begin
					i_q     <= '0;
					state_q <= S_SL2;
				end
				S_SL2: state_q <= S_SL3;
				S_SL3: state_q <= S_SL4;
				S_SL4: state_q <= S_SL5;
				S_SL5: state_q <= S_SL6;
				S_SL6: begin
					if (i_q == cnt_m1) begin
						i_q     <= '0;
						state_q <= S_INIT;
					end else begin
						i_q     <= i_p1;
						state_q <= S_SL2;
					end
				end
				S_INIT: begin
					if (i_q == cnt_m1) begin
						nv_q      <= cnt_q;
						count_q   <= {cnt_q, 1'b0};
						v_q       <= cnt_m1;
						relaxed_q <= 1'b0;
						tcnt_q    <= '0;
						state_q   <= S_LOOP;
					end else begin
						i_q <= i_p1;
					end
				end
				S_LOOP: begin
					if (nv_q <= TWO) begin
						if (tcnt_q == '0) begin
							fst_q   <= eclip_pkg::ST_BAD;
							state_q <= S_FAIL;
						end else begin
							i_q     <= '0;
							state_q <= S_EM0;
						end
					end else if ((count_q == '0) && relaxed_q) begin
						fst_q   <= eclip_pkg::ST_BAD;
						state_q <= S_FAIL;
					end else begin
						if (count_q == '0) begin
							relaxed_q <= 1'b1;
							count_q   <= {nv_q, 1'b0};
						end else begin
							count_q <= count_q - (IW+2)'(1);
						end
						u_q     <= uu;
						v_q     <= vv;
						w_q     <= ww;
						state_q <= S_E0;
					end
				end
				S_E0: state_q <= S_E1;
				S_E1: begin
					ia_q    <= ord_rd;
					state_q <= S_E2;
				end
				S_E2: begin
					ib_q    <= ord_rd;
					state_q <= S_E3;
				end
				S_E3: begin
					ic_q    <= ord_rd;
					state_q <= S_E4;
				end
				S_E4: state_q <= S_E5;
				S_E5: state_q <= S_E6;
				S_E6: state_q <= S_E7;
				S_E7: state_q <= S_E8;
				S_E8: begin
					if (sts.ge_thr) begin
						i_q     <= '0;
						state_q <= S_PL;
					end else begin
						state_q <= S_LOOP;
					end
				end
				S_PL: begin
					if (i_q == nv_q) begin
						state_q <= S_EAR;
					end else if ((i_q == u_q) || (i_q == v_q) || (i_q == w_q)) begin
						i_q <= i_p1;
					end else begin
						state_q <= S_P1;
					end
				end
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: state_q <= S_P5;
				S_P5: begin
					f1_q    <= sts.pos;
					state_q <= S_P6;
				end
				S_P6: begin
					f2_q    <= sts.pos;
					state_q <= S_P7;
				end
				S_P7: begin
					// a probe inside the ear rejects it
					if (sts.pos && f1_q && f2_q) begin
						state_q <= S_LOOP;
					end else begin
						i_q     <= i_p1;
						state_q <= S_PL;
					end
				end
				S_EAR: begin
					tcnt_q  <= tcnt_q + ONE;
					i_q     <= v_q;
					state_q <= S_SHF;
				end
				S_SHF: begin
					// close the gap left by the clipped corner
					if (i_p1 < nv_q) begin
						state_q <= S_SHW;
					end else begin
						nv_q    <= nv_q - ONE;
						count_q <= {nv_q - ONE, 1'b0};
						state_q <= S_LOOP;
					end
				end
				S_SHW: begin
					i_q     <= i_p1;
					state_q <= S_SHF;
				end
				S_FAIL: begin
					olast_q <= 1'b1;
					state_q <= S_OWAIT;
				end
				S_EM0: state_q <= S_EM1;
				S_EM1: begin
					olast_q <= (i_q == (tcnt_q - ONE));
					state_q <= S_OWAIT;
				end
				S_OWAIT: begin
					if (out_ready) begin
						if (olast_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							tcnt_q  <= '0;
							state_q <= S_LOAD;
						end else begin
							i_q     <= i_p1;
							state_q <= S_EM0;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input and output sides active together");

	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (tcnt_q == '0))
		else $error("triangle count not cleared while loading");

	a_tri_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tcnt_q <= MAXV)
		else $error("triangle count past store depth");

	a_ring_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_E0) |-> (nv_q > TWO))
		else $error("ear test on a degenerate ring");
`endif

endmodule

FILE: rtl/core/ear_clip_triangulator.sv
// Channel   | Dir  | Payload                                        | Beat
// vertex    | in   | vertex_x, vertex_y, last_vertex                | one vertex
// triangle  | out  | corner_a, corner_b, corner_c, status, last_result | one result
// cfg       | in   | data (ear_threshold)                           | one register write
//
// Loading takes one vertex per cycle. After the last vertex the controller walks the
// store: it forms the winding sum, writes the order list, then per ear attempt reads
// the candidate corners, tests each remaining vertex against the ear and on a clip
// shifts the order list entries down. The sequence is set by the single read port of
// each memory and the shared two-stage cross product unit. Reset (arst_n) clears the
// controller and sets the threshold to 1. Output stalls hold the sequencer; no vertex
// is taken until the last result leaves.
module ear_clip_triangulator #(
	parameter int MAX_VERTICES = eclip_pkg::MAX_VERTICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	eclip_vtx_if.sink   vertex,
	eclip_tri_if.source triangle,
	eclip_cfg_if.sink   cfg
);
	localparam int IW = $clog2(MAX_VERTICES);

	eclip_pkg::eclip_cmd_t       cmd;
	eclip_pkg::eclip_sts_t       sts;
	logic [IW-1:0]               vaddr, oaddr, o_waddr, o_wdata, ord_rd, taddr, t_waddr;
	logic [eclip_pkg::TRI_W-1:0] t_wdata;

	// Register writes are always taken
	assign cfg.ready = 1'b1;

	eclip_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vertex.valid),
		.in_last  (vertex.last_vertex),
		.in_ready (vertex.ready),
		.out_valid(triangle.valid),
		.out_ready(triangle.ready),
		.cmd      (cmd),
		.sts      (sts),
		.vaddr    (vaddr),
		.oaddr    (oaddr),
		.o_waddr  (o_waddr),
		.o_wdata  (o_wdata),
		.ord_rd   (ord_rd),
		.taddr    (taddr),
		.t_waddr  (t_waddr),
		.t_wdata  (t_wdata)
	);

	eclip_dp #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.vaddr      (vaddr),
		.vertex_x   (vertex.vertex_x),
		.vertex_y   (vertex.vertex_y),
		.oaddr      (oaddr),
		.o_waddr    (o_waddr),
		.o_wdata    (o_wdata),
		.ord_rd     (ord_rd),
		.taddr      (taddr),
		.t_waddr    (t_waddr),
		.t_wdata    (t_wdata),
		.cfg_we     (cfg.valid),
		.cfg_data   (cfg.data),
		.corner_a   (triangle.corner_a),
		.corner_b   (triangle.corner_b),
		.corner_c   (triangle.corner_c),
		.status     (triangle.status),
		.last_result(triangle.last_result)
	);

endmodule
